>>> hdl/rsit_pkg.sv
package rsit_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic signed [63:0] stamp;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
    logic       evicted;
    logic [5:0] occupancy;
  } out_item_t;

  localparam logic [1:0] MODE_QUERY  = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OWN  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic CFG_OWN_HIGH = 1'b0;
  localparam logic CFG_OWN_LOW  = 1'b1;

  // datapath memory operations
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // write data source
  localparam logic WSRC_HOLD = 1'b0;
  localparam logic WSRC_ITEM = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic       wsrc;
  } dp_cmd_t;

  typedef struct packed {
    logic id_match;
    logic older;
  } dp_stat_t;

endpackage

>>> hdl/recency_sorted_id_table_top.sv
// a query scans the entries in order, each with a read state and a check state;
// an update that moves or evicts an entry also shifts entries, each with a read state and a write state
// throughput: one item at a time, set by the single-port entry memory walked by the controller
// next item is taken the cycle after a result is posted; a waiting result only holds the fsm
// reset: rst synchronous, clears entry count, own id and handshake state; memory is not cleared
module recency_sorted_id_table_top #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsit_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsit_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [63:0]         cfg_data
);
  import rsit_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] own_high, own_low;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [AW-1:0] addr;
  in_item_t    item;
  logic        busy;

  // config register writes, always accepted
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      own_high <= '0;
      own_low  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_OWN_HIGH) begin
        own_high <= cfg_data;
      end else begin
        own_low <= cfg_data;
      end
    end
  end

  // result register sits in the controller; a new item may run while a result waits
  rsit_ctrl #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .own_high(own_high), .own_low(own_low),
    .cmd(cmd), .addr(addr), .item(item), .stat(stat), .busy(busy)
  );

  rsit_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_dp (
    .clk(clk), .cmd(cmd), .addr(addr), .item(item), .stat(stat)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> busy) else $error("accepted item not in progress");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall) else $error("input open while busy");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data))) else $error("result dropped");
endmodule

>>> hdl/rsit_datapath.sv
module rsit_datapath #(
  parameter int TABLE_DEPTH = 32,
  parameter int AW = 5
) (
  input  logic                 clk,
  input  rsit_pkg::dp_cmd_t    cmd,
  input  logic [AW-1:0]        addr,
  input  rsit_pkg::in_item_t   item,
  output rsit_pkg::dp_stat_t   stat
);
  import rsit_pkg::*;

  logic [191:0] mem [TABLE_DEPTH];
  logic [191:0] rd;
  logic [191:0] hold;

  // read data is registered; rd keeps the entry carried along by a shift, hold mirrors it for the compares
  always_ff @(posedge clk) begin
    if (cmd.op == OP_READ) begin
      rd <= mem[addr];
    end else if (cmd.op == OP_WRITE) begin
      if (cmd.wsrc == WSRC_ITEM) begin
        mem[addr] <= {item.id_high, item.id_low, item.stamp};
      end else begin
        mem[addr] <= rd;
      end
    end
  end

  always_comb begin
    hold = rd;
    stat.id_match = (hold[191:128] == item.id_high) && (hold[127:64] == item.id_low);
    stat.older = $signed(item.stamp) > $signed(hold[63:0]);
  end
endmodule

>>> hdl/rsit_ctrl.sv
module rsit_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rsit_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rsit_pkg::out_item_t out_data,
  input  logic [63:0]         own_high,
  input  logic [63:0]         own_low,
  output rsit_pkg::dp_cmd_t   cmd,
  output logic [AW-1:0]       addr,
  output rsit_pkg::in_item_t  item,
  input  rsit_pkg::dp_stat_t  stat,
  output logic                busy
);
  import rsit_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FRD    = 4'd1; // read entry for find
  localparam logic [3:0] S_FCHK   = 4'd2;
  localparam logic [3:0] S_DRD    = 4'd3; // delete: read i+1
  localparam logic [3:0] S_DWR    = 4'd4; // delete: write i
  localparam logic [3:0] S_PRD    = 4'd5; // position scan read
  localparam logic [3:0] S_PCHK   = 4'd6;
  localparam logic [3:0] S_IRD    = 4'd7; // insert: read i-1
  localparam logic [3:0] S_IWR    = 4'd8; // insert: write i
  localparam logic [3:0] S_IPUT   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0]    state;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] lim;
  logic          found;
  logic [1:0]    status;
  logic          evicted;
  in_item_t      cur;
  logic          zero_id, own_id, full;
  logic          post;

  assign item    = cur;
  assign zero_id = (cur.id_high == '0) && (cur.id_low == '0);
  assign own_id  = (cur.id_high == own_high) && (cur.id_low == own_low);
  assign full    = (count == CW'(TABLE_DEPTH));
  assign in_stall = (state != S_IDLE);
  assign busy     = (state != S_IDLE);
  assign post     = (state == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_data;
            found <= 1'b0;
            status <= ST_DONE;
            evicted <= 1'b0;
            idx <= '0;
            state <= S_FRD;
          end
        end
        S_FRD: begin
          if (idx >= count) begin
            // not present
            if (cur.mode == MODE_UPDATE) begin
              if (zero_id) begin
                status <= ST_ZERO;
                state <= S_OUT;
              end else if (own_id) begin
                status <= ST_OWN;
                state <= S_OUT;
              end else begin
                idx <= '0;
                state <= S_PRD;
              end
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (stat.id_match) begin
            found <= 1'b1;
            if (cur.mode == MODE_UPDATE) begin
              if (zero_id) begin
                status <= ST_ZERO;
                state <= S_OUT;
              end else if (own_id) begin
                status <= ST_OWN;
                state <= S_OUT;
              end else begin
                state <= S_DRD;
              end
            end else if (cur.mode == MODE_REMOVE) begin
              state <= S_DRD;
            end else begin
              state <= S_OUT;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_FRD;
          end
        end
        S_DRD: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            if (cur.mode == MODE_UPDATE) begin
              idx <= '0;
              state <= S_PRD;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          idx <= idx + 1'b1;
          state <= S_DRD;
        end
        S_PRD: begin
          if (idx >= count) begin
            if (full) begin
              status <= ST_FULL;
              state <= S_OUT;
            end else begin
              lim <= idx;
              idx <= count;
              state <= S_IRD;
            end
          end else begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (stat.older) begin
            lim <= idx;
            if (full) begin
              evicted <= 1'b1;
              idx <= count - 1'b1;
              count <= count - 1'b1;
            end else begin
              idx <= count;
            end
            state <= S_IRD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_PRD;
          end
        end
        S_IRD: begin
          if (idx == lim) begin
            state <= S_IPUT;
          end else begin
            state <= S_IWR;
          end
        end
        S_IWR: begin
          idx <= idx - 1'b1;
          state <= S_IRD;
        end
        S_IPUT: begin
          count <= count + 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (post) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
    end
  end

  // S_OUT waits for the previous result to be taken before posting
  always_ff @(posedge clk) begin
    if (post) begin
      out_data.found <= found;
      out_data.status <= status;
      out_data.evicted <= evicted;
      out_data.occupancy <= 6'(count);
    end
  end

  always_comb begin
    cmd.op = OP_NONE;
    cmd.wsrc = WSRC_HOLD;
    addr = idx[AW-1:0];
    case (state)
      S_FRD:  if (idx < count) cmd.op = OP_READ;
      S_DRD:  begin
        addr = AW'(idx + 1'b1);
        if (idx + 1'b1 < count) cmd.op = OP_READ;
      end
      S_DWR:  cmd.op = OP_WRITE;
      S_PRD:  if (idx < count) cmd.op = OP_READ;
      S_IRD:  begin
        addr = AW'(idx - 1'b1);
        if (idx != lim) cmd.op = OP_READ;
      end
      S_IWR:  cmd.op = OP_WRITE;
      S_IPUT: begin
        cmd.op = OP_WRITE;
        cmd.wsrc = WSRC_ITEM;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && evicted) |-> (status == ST_DONE && cur.mode == MODE_UPDATE))
    else $error("eviction outside update");
  a_idle_after_out: assert property (@(posedge clk) disable iff (rst)
    post |=> (state == S_IDLE && out_valid)) else $error("result not posted");
endmodule

>>> test/recency_sorted_id_table_top_tb.sv
`timescale 1ns / 100ps

module recency_sorted_id_table_top_tb;
  import rsit_pkg::*;

  localparam int DEPTH = 32;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SETTLE_CYCLES = 4 * DEPTH + 40;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [63:0] cfg_data;

  recency_sorted_id_table_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow copy of the table, newest first
  logic [63:0] tbl_high [DEPTH];
  logic [63:0] tbl_low [DEPTH];
  logic signed [63:0] tbl_stamp [DEPTH];
  int tbl_count;
  logic [63:0] own_high;
  logic [63:0] own_low;

  out_item_t pending_results[$];
  int mismatches;

  // idling control
  bit no_idle;
  bit hold_receiver;
  int hold_cycles;

  // small pool of identifiers so updates hit existing entries often
  logic [63:0] pool_high [48];
  logic [63:0] pool_low [48];

  typedef struct {
    in_item_t item;
    bit has_fixed;
    out_item_t fixed;
  } stim_row_t;

  stim_row_t directed [DIRECTED_ROWS];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("recency_sorted_id_table_top_tb failed");
    $finish;
  end

  function automatic int find_id(logic [63:0] hi, logic [63:0] lo);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_high[i] == hi && tbl_low[i] == lo) return i;
    return -1;
  endfunction

  // apply one item to the shadow table and return the result it should give
  function automatic out_item_t apply_table_op(in_item_t it);
    out_item_t r;
    int where;
    int pos;
    where = find_id(it.id_high, it.id_low);
    r.found = (where >= 0);
    r.status = ST_DONE;
    r.evicted = 1'b0;
    if (it.mode == MODE_UPDATE) begin
      if (it.id_high == 64'd0 && it.id_low == 64'd0) begin
        r.status = ST_ZERO;
      end else if (it.id_high == own_high && it.id_low == own_low) begin
        r.status = ST_OWN;
      end else begin
        if (where >= 0) begin
          for (int i = where; i + 1 < tbl_count; i++) begin
            tbl_high[i] = tbl_high[i+1];
            tbl_low[i] = tbl_low[i+1];
            tbl_stamp[i] = tbl_stamp[i+1];
          end
          tbl_count--;
        end
        pos = 0;
        while (pos < tbl_count && !(it.stamp > tbl_stamp[pos])) pos++;
        if (tbl_count >= DEPTH && pos >= tbl_count) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_count >= DEPTH) begin
            tbl_count = DEPTH - 1;
            r.evicted = 1'b1;
          end
          for (int i = tbl_count; i > pos; i--) begin
            tbl_high[i] = tbl_high[i-1];
            tbl_low[i] = tbl_low[i-1];
            tbl_stamp[i] = tbl_stamp[i-1];
          end
          tbl_high[pos] = it.id_high;
          tbl_low[pos] = it.id_low;
          tbl_stamp[pos] = it.stamp;
          tbl_count++;
        end
      end
    end else if (it.mode == MODE_REMOVE && where >= 0) begin
      for (int i = where; i + 1 < tbl_count; i++) begin
        tbl_high[i] = tbl_high[i+1];
        tbl_low[i] = tbl_low[i+1];
        tbl_stamp[i] = tbl_stamp[i+1];
      end
      tbl_count--;
    end
    r.occupancy = tbl_count[5:0];
    return r;
  endfunction

  // append one expected result
  function automatic void queue_expected(out_item_t r);
    pending_results = {pending_results, r};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] edge_stamp();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'd0;
      3: return rand64();
      default: return 64'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  function automatic in_item_t make_random_item();
    in_item_t it;
    int k;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) it.mode = MODE_UPDATE;
    else if (sel < 75) it.mode = MODE_REMOVE;
    else if (sel < 97) it.mode = MODE_QUERY;
    else it.mode = 2'd3;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      k = $urandom_range(0, 47);
      it.id_high = pool_high[k];
      it.id_low = pool_low[k];
    end else if (sel < 90) begin
      it.id_high = 64'd0;
      it.id_low = 64'd0;
    end else if (sel < 94) begin
      it.id_high = own_high;
      it.id_low = own_low;
    end else begin
      it.id_high = rand64();
      it.id_low = rand64();
    end
    it.stamp = edge_stamp();
    return it;
  endfunction

  // one accepted transfer on the input channel; valid stays up for a following item
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic offer_item(in_item_t it);
    if (!no_idle)
      while ($urandom_range(0, 99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    queue_expected(apply_table_op(it));
    send_item(it);
  endtask

  task automatic drain_and_settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // valid stays up for a following write; the caller drops it
  task automatic write_reg(logic idx, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OWN_HIGH) own_high = value;
    else own_low = value;
  endtask

  function automatic in_item_t mk(logic [1:0] m, logic [63:0] hi, logic [63:0] lo,
                                  logic [63:0] st);
    in_item_t it;
    it.mode = m;
    it.id_high = hi;
    it.id_low = lo;
    it.stamp = st;
    return it;
  endfunction

  function automatic out_item_t res(logic f, logic [1:0] s, logic e, logic [5:0] occ);
    out_item_t r;
    r.found = f;
    r.status = s;
    r.evicted = e;
    r.occupancy = occ;
    return r;
  endfunction

  // receiver: random stall, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_receiver) begin
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 32);
    end
  end

  // long hold-off counted here in cycles
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      hold_receiver <= (hold_cycles > 1);
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found || out_data.status !== want.status ||
            out_data.evicted !== want.evicted || out_data.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected found=%0d status=%0d evicted=%0d occ=%0d,",
                      " got found=%0d status=%0d evicted=%0d occ=%0d"},
                     want.found, want.status, want.evicted, want.occupancy,
                     out_data.found, out_data.status, out_data.evicted, out_data.occupancy);
        end
      end
    end
  end

  initial begin
    int issued;
    int phase_len;
    logic [63:0] all_ones;
    all_ones = '1;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_OWN_HIGH;
    cfg_data = '0;
    mismatches = 0;
    no_idle = 0;
    hold_receiver = 0;
    hold_cycles = 0;
    tbl_count = 0;
    own_high = '0;
    own_low = '0;
    for (int i = 0; i < 48; i++) begin
      pool_high[i] = (i < 4) ? 64'd0 : rand64();
      pool_low[i] = (i == 0) ? 64'd1 : rand64();
    end
    pool_high[1] = all_ones;
    pool_low[1] = all_ones;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: own id is still zero here, so zero id hits the zero check first
    directed[0] = '{mk(MODE_QUERY, 64'd5, 64'd5, 64'd0), 1, res(0, ST_DONE, 0, 0)};
    directed[1] = '{mk(MODE_UPDATE, 64'd0, 64'd0, 64'd3), 1, res(0, ST_ZERO, 0, 0)};
    directed[2] = '{mk(MODE_REMOVE, 64'd5, 64'd5, 64'd0), 1, res(0, ST_DONE, 0, 0)};
    directed[3] = '{mk(MODE_UPDATE, all_ones, all_ones, 64'h7fff_ffff_ffff_ffff), 1,
                    res(0, ST_DONE, 0, 1)};
    directed[4] = '{mk(MODE_UPDATE, 64'd0, 64'd1, 64'h8000_0000_0000_0000), 1,
                    res(0, ST_DONE, 0, 2)};
    directed[5] = '{mk(MODE_QUERY, all_ones, all_ones, 64'd0), 1, res(1, ST_DONE, 0, 2)};
    directed[6] = '{mk(MODE_UPDATE, 64'd7, 64'd7, 64'd0), 0, '0};
    directed[7] = '{mk(MODE_UPDATE, 64'd8, 64'd8, 64'd0), 0, '0};   // equal stamp
    directed[8] = '{mk(MODE_UPDATE, 64'd7, 64'd7, 64'd10), 0, '0};  // move existing
    directed[9] = '{mk(2'd3, 64'd7, 64'd7, 64'd0), 0, '0};           // undefined mode
    directed[10] = '{mk(MODE_REMOVE, 64'd7, 64'd7, 64'd0), 0, '0};
    directed[11] = '{mk(MODE_QUERY, 64'd7, 64'd7, 64'd0), 0, '0};
    directed[12] = '{mk(MODE_UPDATE, 64'd8, 64'd8, 64'h8000_0000_0000_0000), 0, '0};
    for (int i = 13; i < DIRECTED_ROWS; i++)
      directed[i] = '{mk(MODE_UPDATE, 64'd100 + i, 64'(i),
                         64'($signed(i) - 16)), 0, '0};

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      out_item_t got;
      got = apply_table_op(directed[i].item);
      if (directed[i].has_fixed && got !== directed[i].fixed) begin
        mismatches++;
        $display("table row %0d disagrees with prediction", i);
      end
      queue_expected(got);
      send_item(directed[i].item);
    end
    drain_and_settle();

    // own id at the all-ones extreme, then fill the table to exercise eviction and drop
    write_reg(CFG_OWN_HIGH, all_ones);
    write_reg(CFG_OWN_LOW, all_ones);
    cfg_valid <= 1'b0;
    for (int i = 0; i < DEPTH + 6; i++)
      offer_item(mk(MODE_UPDATE, 64'd500 + i, 64'd1, 64'($signed(i) * 3 - 40)));
    offer_item(mk(MODE_UPDATE, all_ones, all_ones, 64'd0));             // own id
    offer_item(mk(MODE_UPDATE, 64'd900, 64'd1, 64'h8000_0000_0000_0000)); // dropped
    offer_item(mk(MODE_UPDATE, 64'd901, 64'd1, 64'h7fff_ffff_ffff_ffff)); // evicts
    drain_and_settle();

    // random phases, changing own id between them
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          write_reg(CFG_OWN_HIGH, 64'd0);
          write_reg(CFG_OWN_LOW, pool_low[$urandom_range(4, 47)]);
        end
        1: begin
          int k;
          k = $urandom_range(4, 47);
          write_reg(CFG_OWN_HIGH, pool_high[k]);
          write_reg(CFG_OWN_LOW, pool_low[k]);
        end
        2: write_reg(CFG_OWN_LOW, rand64());
        default: write_reg(CFG_OWN_HIGH, rand64());
      endcase
      cfg_valid <= 1'b0;
      phase_len = $urandom_range(150, 300);
      no_idle = (issued >= 600 && issued < 900);
      for (int n = 0; n < phase_len && issued < RANDOM_ITEMS; n++) begin
        // long receiver hold-off while items keep coming
        if (issued == 300) hold_cycles <= 2000;
        offer_item(make_random_item());
        issued++;
      end
      // sender waits for every result before the next register write
      drain_and_settle();
    end
    no_idle = 0;

    drain_and_settle();
    if (pending_results.size() != 0) begin
      $display("recency_sorted_id_table_top_tb failed");
      $finish;
    end else begin
      if (mismatches == 0)
        $display("recency_sorted_id_table_top_tb passed");
      else
        $display("recency_sorted_id_table_top_tb failed");
      $finish;
    end
  end

endmodule
